// ===== hw/rtl/pft_pkg.sv =====
// pft_pkg: constants, stage map and shared types of the oriented triangle plane block.
// No dependencies; used by the channel interfaces and the top level.
package pft_pkg;

   // fixed point formats
   localparam int NORMAL_FRAC_BITS = 30;
   localparam int CoordW = 32;
   localparam int OutW = 32;

   // normalized cross product magnitude is held in [2^29, 2^30)
   localparam int VnW = 30;
   // quotient bits of the normalizing divide (normal magnitude up to 2^NORMAL_FRAC_BITS)
   localparam int QW = NORMAL_FRAC_BITS + 1;
   // numerator width of the normalizing divide
   localparam int NumW = VnW + NORMAL_FRAC_BITS + 1;
   // square root steps, one result bit each
   localparam int SqSteps = 32;

   // pipeline stage map
   localparam int ST_EDGE   = 0;
   localparam int ST_SCALE  = 1;
   localparam int ST_MUL    = 2;
   localparam int ST_CROSS  = 3;
   localparam int ST_COARSE = 4;
   localparam int ST_FINE   = 5;
   localparam int ST_SQR    = 6;
   localparam int ST_SUM    = 7;
   localparam int ST_SQRT0  = 8;
   localparam int ST_DIVI   = ST_SQRT0 + SqSteps;
   localparam int ST_NORM   = ST_DIVI + QW + 1;
   localparam int ST_DOT    = ST_NORM + 1;
   localparam int ST_ACC    = ST_DOT + 1;
   localparam int ST_FLIP   = ST_ACC + 1;
   localparam int ST_OUT    = ST_FLIP + 1;
   localparam int NumStages = ST_OUT + 1;

   // one input item, index 0 is x
   typedef struct packed {
      logic [2:0][CoordW-1:0] a;
      logic [2:0][CoordW-1:0] b;
      logic [2:0][CoordW-1:0] c;
      logic [2:0][CoordW-1:0] r;
   } req_type;

   // values that ride alongside the arithmetic through the pipeline
   typedef struct packed {
      logic [2:0][CoordW-1:0] a;
      logic [2:0][CoordW-1:0] r;
      logic [2:0]             vsgn;
      logic                   degen;
      logic [2:0][VnW-1:0]    vn;
      logic [2:0][OutW-1:0]   nrm;
   } side_type;

endpackage

// ===== hw/rtl/pft_if.sv =====
// pft_if: valid/ready channel interfaces for the triangle input and the plane result.
// Depends on pft_pkg for field widths.
interface pft_req_if;
   import pft_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] ax, ay, az;
   logic signed [CoordW-1:0] bx, by_coord, bz;
   logic signed [CoordW-1:0] cx, cy, cz;
   logic signed [CoordW-1:0] ref_x, ref_y, ref_z;

   modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                   ref_x, ref_y, ref_z, input ready);
   modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                   ref_x, ref_y, ref_z, output ready);
endinterface

interface pft_rsp_if;
   import pft_pkg::*;
   logic                   valid;
   logic                   ready;
   logic signed [OutW-1:0] normal_x, normal_y, normal_z;
   logic signed [OutW-1:0] plane_offset;
   logic                   ref_behind;
   logic                   degenerate;

   modport source (output valid, normal_x, normal_y, normal_z, plane_offset,
                   ref_behind, degenerate, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, plane_offset,
                   ref_behind, degenerate, output ready);
endinterface

// ===== hw/rtl/plane_from_triangle_oriented_top.sv =====
// Oriented plane through a triangle, computed in a pipeline of 77 stages (edge, scale,
// multiply, cross, two normalize steps, square, sum, 32 square root steps, 32 divide steps,
// normal sign, then dot, accumulate, flip, round). Throughput is one item per cycle; the
// whole pipeline stalls only while a result waits, and an input skid register still takes
// one more transfer during such a stall.
// Reset (synchronous, active high) empties the pipeline and sets orient_ff to 1.
module plane_from_triangle_oriented_top (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data,
   pft_req_if.sink   req_bus,
   pft_rsp_if.source rsp_bus
);
   import pft_pkg::*;

   // ---------------------------------------------------------------- control
   logic                 en;
   logic                 in_v;
   logic                 skid_v_ff;
   req_type              skid_ff;
   req_type              req_now;
   req_type              in_item;
   logic [NumStages-1:0] vld_ff;
   logic                 orient_ff;

   side_type side_ff [NumStages];
   side_type side_in [NumStages];

   // ---------------------------------------------------------------- datapath regs
   logic signed [32:0] e1_ff [3], e1_in [3], e2_ff [3], e2_in [3];
   logic signed [30:0] es1_ff [3], es1_in [3], es2_ff [3], es2_in [3];
   logic signed [61:0] pr_ff [6], pr_in [6];
   logic [60:0]        vm_ff [3], vm_in [3];
   logic [2:0]         vsgn_c;
   logic [36:0]        w_ff [3], w_in [3];
   logic [7:0]         topb_ff, topb_in;
   logic               degen_c;
   logic [VnW-1:0]     vn_c [3];
   logic [59:0]        sq_ff [3], sq_in [3];
   logic [61:0]        sum_ff, sum_in;
   logic [63:0]        sv_ff [SqSteps], sv_in [SqSteps];
   logic [63:0]        sr_ff [SqSteps], sr_in [SqSteps];
   logic [2:0][30:0]   dr_ff [QW+1], dr_in [QW+1];
   logic [2:0][QW-1:0] dl_ff [QW+1], dl_in [QW+1];
   logic [2:0][QW-1:0] dq_ff [QW+1], dq_in [QW+1];
   logic [30:0]        dd_ff [QW+1], dd_in [QW+1];
   logic [OutW-1:0]    nrm_c [3];
   logic signed [63:0] dpa_ff [3], dpa_in [3], dpr_ff [3], dpr_in [3];
   logic signed [65:0] pa_ff, pa_in, pq_ff, pq_in;
   logic signed [65:0] paf_ff, paf_in;
   logic               fac_ff, fac_in, dg_ff, dg_in;
   logic [OutW-1:0]    nf_ff [3], nf_in [3];
   logic [OutW-1:0]    onrm_ff [3], onrm_in [3];
   logic [OutW-1:0]    ooff_ff, ooff_in;
   logic               ofac_ff, odeg_ff;

   // ---------------------------------------------------------------- input side
   assign req_now.a = {req_bus.az, req_bus.ay, req_bus.ax};
   assign req_now.b = {req_bus.bz, req_bus.by_coord, req_bus.bx};
   assign req_now.c = {req_bus.cz, req_bus.cy, req_bus.cx};
   assign req_now.r = {req_bus.ref_z, req_bus.ref_y, req_bus.ref_x};

   // pipeline moves unless the result register holds an untaken result
   assign en            = !vld_ff[NumStages-1] || rsp_bus.ready;
   assign req_bus.ready = !skid_v_ff;
   assign in_item       = skid_v_ff ? skid_ff : req_now;
   assign in_v          = skid_v_ff || req_bus.valid;

   // skid register catches a transfer taken during a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else if (en) begin
         skid_v_ff <= 1'b0;
      end else if (req_bus.valid && !skid_v_ff) begin
         skid_v_ff <= 1'b1;
      end
      if (!en && req_bus.valid && !skid_v_ff) begin
         skid_ff <= req_now;
      end
   end

   // valid bits travel with the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NumStages-2:0], in_v};
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff <= 1'b1;
      end else if (csr_wr_en) begin
         orient_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------- edges .. cross
   always_comb begin
      logic [32:0] neg;
      logic [31:0] m1 [3];
      logic [31:0] m2 [3];
      logic [31:0] orv;
      logic [1:0]  k;
      logic [31:0] s;
      logic signed [61:0] v;
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = 33'($signed(in_item.b[i])) - 33'($signed(in_item.a[i]));
         e2_in[i] = 33'($signed(in_item.c[i])) - 33'($signed(in_item.a[i]));
      end
      // edge scaling: shift right until every magnitude is below 2^30
      orv = '0;
      for (int i = 0; i < 3; i++) begin
         neg   = -e1_ff[i];
         m1[i] = e1_ff[i][32] ? neg[31:0] : e1_ff[i][31:0];
         neg   = -e2_ff[i];
         m2[i] = e2_ff[i][32] ? neg[31:0] : e2_ff[i][31:0];
         orv   = orv | m1[i] | m2[i];
      end
      k = orv[31] ? 2'd2 : (orv[30] ? 2'd1 : 2'd0);
      for (int i = 0; i < 3; i++) begin
         s         = m1[i] >> k;
         es1_in[i] = e1_ff[i][32] ? -$signed({1'b0, s[29:0]}) : $signed({1'b0, s[29:0]});
         s         = m2[i] >> k;
         es2_in[i] = e2_ff[i][32] ? -$signed({1'b0, s[29:0]}) : $signed({1'b0, s[29:0]});
      end
      // cross product terms
      pr_in[0] = es1_ff[1] * es2_ff[2];
      pr_in[1] = es1_ff[2] * es2_ff[1];
      pr_in[2] = es1_ff[2] * es2_ff[0];
      pr_in[3] = es1_ff[0] * es2_ff[2];
      pr_in[4] = es1_ff[0] * es2_ff[1];
      pr_in[5] = es1_ff[1] * es2_ff[0];
      for (int i = 0; i < 3; i++) begin
         v         = pr_ff[2*i] - pr_ff[2*i+1];
         vsgn_c[i] = v[61];
         neg       = '0;
         vm_in[i]  = v[61] ? 61'(-v) : v[60:0];
      end
   end

   // ---------------------------------------------------------------- normalize shift
   // coarse step picks the top nonzero byte, fine step the top bit inside it
   always_comb begin
      logic [63:0] o64;
      logic [2:0]  ph;
      logic [2:0]  pl;
      logic [89:0] wide;
      logic [63:0] ot;
      o64 = {3'b000, vm_ff[0] | vm_ff[1] | vm_ff[2]};
      ph  = '0;
      for (int g = 0; g < 8; g++) begin
         if (o64[8*g +: 8] != 8'd0) ph = 3'(g);
      end
      degen_c = (o64 == 64'd0);
      ot      = o64 >> {ph, 3'b000};
      topb_in = ot[7:0];
      for (int i = 0; i < 3; i++) begin
         wide    = {vm_ff[i], 29'd0} >> {ph, 3'b000};
         w_in[i] = wide[36:0];
      end
      pl = '0;
      for (int b = 0; b < 8; b++) begin
         if (topb_ff[b]) pl = 3'(b);
      end
      for (int i = 0; i < 3; i++) begin
         vn_c[i] = VnW'(w_ff[i] >> pl);
      end
   end

   // ---------------------------------------------------------------- length
   always_comb begin
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = side_ff[ST_FINE].vn[i] * side_ff[ST_FINE].vn[i];
      end
      sum_in = 62'(sq_ff[0]) + 62'(sq_ff[1]) + 62'(sq_ff[2]);
      // one square root bit per stage
      for (int j = 0; j < SqSteps; j++) begin
         v    = (j == 0) ? {2'b00, sum_ff} : sv_ff[(j == 0) ? 0 : j-1];
         res  = (j == 0) ? 64'd0 : sr_ff[(j == 0) ? 0 : j-1];
         bitv = 64'd1 << (62 - 2*j);
         if (v >= res + bitv) begin
            sv_in[j] = v - (res + bitv);
            sr_in[j] = (res >> 1) + bitv;
         end else begin
            sv_in[j] = v;
            sr_in[j] = res >> 1;
         end
      end
   end

   // ---------------------------------------------------------------- divide
   always_comb begin
      logic [30:0]     len;
      logic [NumW-1:0] num;
      logic [31:0]     t;
      len      = sr_ff[SqSteps-1][30:0];
      dd_in[0] = len;
      for (int i = 0; i < 3; i++) begin
         num         = {side_ff[ST_DIVI-1].vn[i], {NORMAL_FRAC_BITS{1'b0}}}
                       + NumW'(len >> 1);
         dr_in[0][i] = 31'(num >> QW);
         dl_in[0][i] = num[QW-1:0];
         dq_in[0][i] = '0;
      end
      // restoring divide, one quotient bit per stage
      for (int j = 1; j <= QW; j++) begin
         dd_in[j] = dd_ff[j-1];
         for (int i = 0; i < 3; i++) begin
            t           = {dr_ff[j-1][i], dl_ff[j-1][i][QW-1]};
            dl_in[j][i] = dl_ff[j-1][i] << 1;
            if (t >= {1'b0, dd_ff[j-1]}) begin
               dr_in[j][i] = 31'(t - {1'b0, dd_ff[j-1]});
               dq_in[j][i] = {dq_ff[j-1][i][QW-2:0], 1'b1};
            end else begin
               dr_in[j][i] = t[30:0];
               dq_in[j][i] = {dq_ff[j-1][i][QW-2:0], 1'b0};
            end
         end
      end
   end

   // ---------------------------------------------------------------- normal, offset
   always_comb begin
      logic [OutW-1:0] qq;
      logic [65:0]     pm;
      logic [65:0]     qo;
      for (int i = 0; i < 3; i++) begin
         qq = OutW'(dq_ff[QW][i]);
         if (side_ff[ST_NORM-1].degen) nrm_c[i] = '0;
         else if (side_ff[ST_NORM-1].vsgn[i]) nrm_c[i] = -qq;
         else nrm_c[i] = qq;
      end
      for (int i = 0; i < 3; i++) begin
         dpa_in[i] = $signed(side_ff[ST_DOT-1].nrm[i]) * $signed(side_ff[ST_DOT-1].a[i]);
         dpr_in[i] = $signed(side_ff[ST_DOT-1].nrm[i]) * $signed(side_ff[ST_DOT-1].r[i]);
      end
      pa_in = 66'(dpa_ff[0]) + 66'(dpa_ff[1]) + 66'(dpa_ff[2]);
      pq_in = 66'(dpr_ff[0]) + 66'(dpr_ff[1]) + 66'(dpr_ff[2]);
      // orientation flip
      fac_in = pq_ff < pa_ff;
      dg_in  = side_ff[ST_FLIP-1].degen;
      if (orient_ff && !fac_in) begin
         paf_in = -pa_ff;
         for (int i = 0; i < 3; i++) nf_in[i] = -side_ff[ST_FLIP-1].nrm[i];
      end else begin
         paf_in = pa_ff;
         for (int i = 0; i < 3; i++) nf_in[i] = side_ff[ST_FLIP-1].nrm[i];
      end
      // round half away from zero, then saturate
      pm = paf_ff[65] ? 66'(-paf_ff) : 66'(paf_ff);
      qo = (pm + (66'd1 << (NORMAL_FRAC_BITS - 1))) >> NORMAL_FRAC_BITS;
      if (paf_ff[65]) begin
         ooff_in = (qo > 66'h0_8000_0000) ? 32'h8000_0000 : 32'(-qo);
      end else begin
         ooff_in = (qo > 66'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : qo[31:0];
      end
      for (int i = 0; i < 3; i++) onrm_in[i] = nf_ff[i];
   end

   // ---------------------------------------------------------------- side line
   always_comb begin
      side_in[0]   = '0;
      side_in[0].a = in_item.a;
      side_in[0].r = in_item.r;
      for (int s = 1; s < NumStages; s++) side_in[s] = side_ff[s-1];
      side_in[ST_CROSS].vsgn   = vsgn_c;
      side_in[ST_COARSE].degen = degen_c;
      for (int i = 0; i < 3; i++) begin
         side_in[ST_FINE].vn[i]  = vn_c[i];
         side_in[ST_NORM].nrm[i] = nrm_c[i];
      end
   end

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NumStages; s++) side_ff[s] <= side_in[s];
         for (int i = 0; i < 3; i++) begin
            e1_ff[i]   <= e1_in[i];
            e2_ff[i]   <= e2_in[i];
            es1_ff[i]  <= es1_in[i];
            es2_ff[i]  <= es2_in[i];
            vm_ff[i]   <= vm_in[i];
            w_ff[i]    <= w_in[i];
            sq_ff[i]   <= sq_in[i];
            dpa_ff[i]  <= dpa_in[i];
            dpr_ff[i]  <= dpr_in[i];
            nf_ff[i]   <= nf_in[i];
            onrm_ff[i] <= onrm_in[i];
         end
         for (int i = 0; i < 6; i++) pr_ff[i] <= pr_in[i];
         topb_ff <= topb_in;
         sum_ff  <= sum_in;
         for (int j = 0; j < SqSteps; j++) begin
            sv_ff[j] <= sv_in[j];
            sr_ff[j] <= sr_in[j];
         end
         for (int j = 0; j <= QW; j++) begin
            dr_ff[j] <= dr_in[j];
            dl_ff[j] <= dl_in[j];
            dq_ff[j] <= dq_in[j];
            dd_ff[j] <= dd_in[j];
         end
         pa_ff   <= pa_in;
         pq_ff   <= pq_in;
         paf_ff  <= paf_in;
         fac_ff  <= fac_in;
         dg_ff   <= dg_in;
         ooff_ff <= ooff_in;
         ofac_ff <= fac_ff;
         odeg_ff <= dg_ff;
      end
   end

   // ---------------------------------------------------------------- result channel
   assign rsp_bus.valid        = vld_ff[NumStages-1];
   assign rsp_bus.normal_x     = $signed(onrm_ff[0]);
   assign rsp_bus.normal_y     = $signed(onrm_ff[1]);
   assign rsp_bus.normal_z     = $signed(onrm_ff[2]);
   assign rsp_bus.plane_offset = $signed(ooff_ff);
   assign rsp_bus.ref_behind   = ofac_ff;
   assign rsp_bus.degenerate   = odeg_ff;

endmodule

// ===== tb/sv/plane_from_triangle_oriented_top_test.sv =====
// plane_from_triangle_oriented_top_test: self-checking testbench of the oriented triangle
// plane block. Depends on pft_pkg, pft_if and plane_from_triangle_oriented_top.
module plane_from_triangle_oriented_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pft_pkg::*;

   localparam int LATENCY = 76;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 200;

   typedef struct {
      logic signed [31:0] nx, ny, nz, off;
      logic               facing, degen;
   } plane_type;

   typedef struct {
      logic signed [31:0] v[12];
   } tri_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   pft_req_if req_bus ();
   pft_rsp_if rsp_bus ();

   plane_from_triangle_oriented_top u_dut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   tri_type   pending_tris[$];
   plane_type expected_planes[$];
   logic      orient_on = 1'b1;
   int        error_count = 0;
   int        cycle_count = 0;
   int        planes_checked = 0;
   int        degen_seen = 0;
   bit        calm = 1'b0;
   bit        hold_rsp = 1'b0;
   int        hold_left = 0;

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint unsigned magn(longint x);
      return x < 0 ? longint'(-x) : longint'(x);
   endfunction

   function automatic longint shr_keep_sign(longint x, int k);
      longint m;
      m = longint'(magn(x) >> k);
      return x < 0 ? -m : m;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // oriented plane of one triangle
   function automatic plane_type plane_of(tri_type t, logic orient);
      plane_type p;
      longint a[3], r[3], e1[3], e2[3], v[3], n[3];
      longint pa, pr;
      longint unsigned m, sum, len, q;
      int k;
      m = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = t.v[i];
         e1[i] = longint'(t.v[3+i]) - a[i];
         e2[i] = longint'(t.v[6+i]) - a[i];
         r[i] = t.v[9+i];
         if (magn(e1[i]) > m) m = magn(e1[i]);
         if (magn(e2[i]) > m) m = magn(e2[i]);
      end
      k = 0;
      while ((m >> k) >= (64'd1 << 30)) k++;
      for (int i = 0; i < 3; i++) begin
         e1[i] = shr_keep_sign(e1[i], k);
         e2[i] = shr_keep_sign(e2[i], k);
      end
      v[0] = e1[1]*e2[2] - e1[2]*e2[1];
      v[1] = e1[2]*e2[0] - e1[0]*e2[2];
      v[2] = e1[0]*e2[1] - e1[1]*e2[0];
      m = 0;
      for (int i = 0; i < 3; i++) if (magn(v[i]) > m) m = magn(v[i]);
      p.degen = (m == 0);
      if (p.degen) begin
         n[0] = 0; n[1] = 0; n[2] = 0;
      end else begin
         // bring the largest component into [2^29, 2^30)
         k = 0;
         while ((m >> k) >= (64'd1 << 30)) k++;
         if (k > 0) begin
            for (int i = 0; i < 3; i++) v[i] = shr_keep_sign(v[i], k);
         end else begin
            while (m < (64'd1 << 29)) begin
               m <<= 1;
               for (int i = 0; i < 3; i++) v[i] = v[i] * 2;
            end
         end
         sum = 0;
         for (int i = 0; i < 3; i++) sum += magn(v[i]) * magn(v[i]);
         len = int_sqrt(sum);
         for (int i = 0; i < 3; i++) begin
            q = ((magn(v[i]) << NORMAL_FRAC_BITS) + (len >> 1)) / len;
            n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
         end
      end
      pa = n[0]*a[0] + n[1]*a[1] + n[2]*a[2];
      pr = n[0]*r[0] + n[1]*r[1] + n[2]*r[2];
      p.facing = (pr < pa);
      if (orient && !p.facing) begin
         for (int i = 0; i < 3; i++) n[i] = -n[i];
         pa = -pa;
      end
      q = (magn(pa) + (64'd1 << (NORMAL_FRAC_BITS-1))) >> NORMAL_FRAC_BITS;
      if (pa < 0) p.off = q > 64'h8000_0000 ? 32'sh8000_0000 : 32'(-longint'(q));
      else p.off = q > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : 32'(q);
      p.nx = 32'(n[0]);
      p.ny = 32'(n[1]);
      p.nz = 32'(n[2]);
      return p;
   endfunction

   // driver: one transfer per accepting edge, idles at random
   initial begin
      req_bus.valid = 1'b0;
      {req_bus.ax, req_bus.ay, req_bus.az, req_bus.bx, req_bus.by_coord, req_bus.bz} = '0;
      {req_bus.cx, req_bus.cy, req_bus.cz, req_bus.ref_x, req_bus.ref_y, req_bus.ref_z} = '0;
      rsp_bus.ready = 1'b0;
   end

   bit req_fire;
   always @(posedge clock) begin
      req_fire <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready)
         expected_planes.push_back(plane_of(pending_tris.pop_front(), orient_on));
   end

   always @(negedge clock) begin
      if (!reset && (!req_bus.valid || req_fire)) begin
         if (pending_tris.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
            req_bus.valid <= 1'b1;
            {req_bus.ax, req_bus.ay, req_bus.az} <=
               {pending_tris[0].v[0], pending_tris[0].v[1], pending_tris[0].v[2]};
            {req_bus.bx, req_bus.by_coord, req_bus.bz} <=
               {pending_tris[0].v[3], pending_tris[0].v[4], pending_tris[0].v[5]};
            {req_bus.cx, req_bus.cy, req_bus.cz} <=
               {pending_tris[0].v[6], pending_tris[0].v[7], pending_tris[0].v[8]};
            {req_bus.ref_x, req_bus.ref_y, req_bus.ref_z} <=
               {pending_tris[0].v[9], pending_tris[0].v[10], pending_tris[0].v[11]};
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor: compare each result transfer with the oldest expected plane
   always @(posedge clock) begin
      plane_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_planes.size() == 0) begin
            $error("result transfer with no plane expected");
            error_count++;
         end else begin
            e = expected_planes.pop_front();
            planes_checked <= planes_checked + 1;
            if (e.degen) degen_seen <= degen_seen + 1;
            if (rsp_bus.normal_x !== e.nx) begin
               $error("normal_x expected %0d actual %0d", e.nx, rsp_bus.normal_x);
               error_count++;
            end
            if (rsp_bus.normal_y !== e.ny) begin
               $error("normal_y expected %0d actual %0d", e.ny, rsp_bus.normal_y);
               error_count++;
            end
            if (rsp_bus.normal_z !== e.nz) begin
               $error("normal_z expected %0d actual %0d", e.nz, rsp_bus.normal_z);
               error_count++;
            end
            if (rsp_bus.plane_offset !== e.off) begin
               $error("plane_offset expected %0d actual %0d", e.off, rsp_bus.plane_offset);
               error_count++;
            end
            if (rsp_bus.ref_behind !== e.facing) begin
               $error("ref_behind expected %0b actual %0b", e.facing, rsp_bus.ref_behind);
               error_count++;
            end
            if (rsp_bus.degenerate !== e.degen) begin
               $error("degenerate expected %0b actual %0b", e.degen, rsp_bus.degenerate);
               error_count++;
            end
         end
      end
   end

   // receiver readiness, with a long hold-off counted here
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_rsp && hold_left == 0) begin
         hold_left <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= (hold_left == 1);
      end else begin
         rsp_bus.ready <= calm || $urandom_range(99) >= 15;
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(2 * 65536 * 100)) - 65536 * 100;
         default: return $signed($urandom_range(2000)) - 1000;
      endcase
   endfunction

   task automatic add_tri(logic signed [31:0] a0, a1, a2, b0, b1, b2,
                          c0, c1, c2, r0, r1, r2);
      tri_type t;
      t.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2, r0, r1, r2};
      pending_tris.push_back(t);
   endtask

   task automatic add_random(int count);
      tri_type t;
      int mode;
      for (int j = 0; j < count; j++) begin
         mode = $urandom_range(2);
         for (int i = 0; i < 12; i++) t.v[i] = rand_coord(mode);
         // now and then make the triangle collinear
         if ($urandom_range(9) == 0)
            for (int i = 0; i < 3; i++) t.v[6+i] = t.v[i] + 2 * (t.v[3+i] - t.v[i]);
         if ($urandom_range(19) == 0)
            for (int i = 0; i < 3; i++) t.v[3+i] = t.v[i];
         pending_tris.push_back(t);
      end
   endtask

   task automatic drain();
      while (pending_tris.size() != 0 || expected_planes.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_orient(logic value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      orient_on = value;
   endtask

   localparam logic signed [31:0] MAXC = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MINC = 32'sh8000_0000;
   localparam logic signed [31:0] ONE = 32'sh0001_0000;

   // stimulus sequence
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: unit triangles, reference on each side and on the plane
      add_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
      add_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE);
      add_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0);
      add_tri(ONE, ONE, ONE, 2*ONE, ONE, ONE, ONE, 3*ONE, ONE, 0, 0, 0);
      // extremes of the coordinates
      add_tri(MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC, MAXC, MAXC, MAXC);
      add_tri(MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, MAXC, MINC, MINC, MINC);
      add_tri(MAXC, 0, 0, 0, MAXC, 0, 0, 0, MAXC, 0, 0, 0);
      add_tri(MINC, 0, 0, 0, MINC, 0, 0, 0, MINC, MAXC, MAXC, MAXC);
      add_tri(MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MINC, -1, -1, -1);
      // offset at the edge of its range: far plane
      add_tri(MAXC, MAXC, MAXC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, 0, 0, 0);
      // tiny edges, cross product scaled up
      add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 5, 5, 5);
      add_tri(7, -3, 2, 8, -3, 2, 7, -2, 3, 0, 0, 0);
      // collinear and coincident triangles
      add_tri(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 0, 0, ONE);
      add_tri(ONE, 2, 3, ONE, 2, 3, ONE, 2, 3, 0, 0, 0);
      add_tri(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, 0, 0, 0);
      drain();
      // orientation disabled on part of the directed set, plus random
      write_orient(1'b0);
      add_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
      add_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE);
      add_tri(MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC, MAXC, MAXC, MAXC);
      add_tri(MAXC, MAXC, MAXC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, 0, 0, 0);
      add_tri(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 0, 0, ONE);
      add_random(120);
      // receiver holds off while the sender keeps offering
      hold_rsp = 1'b1;
      while (hold_left == 0) @(posedge clock);
      hold_rsp = 1'b0;
      drain();
      write_orient(1'b1);
      add_random(150);
      // sender pauses until every plane has come back
      drain();
      calm = 1'b1;
      add_random(150);
      drain();
      calm = 1'b0;
      write_orient(1'b0);
      add_random(60);
      drain();
      write_orient(1'b1);
      add_random(70);
      drain();
      $display("Checked %0d planes (%0d collinear) over both orientation settings.",
               planes_checked, degen_seen);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
